### rtl/psht_pkg.sv
// Shared types and constants for the page slot hash table.
package psht_pkg;

  localparam int OP_W     = 2;
  localparam int FILE_W   = 16;
  localparam int PAGE_W   = 32;
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 3;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;

  localparam int SUM_W   = 33;
  localparam int DIGIT_W = 8;
  localparam int DIGITS  = (SUM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int PAD_W   = DIGITS * DIGIT_W;
  localparam int CNT_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_REDUNDANT = 3'd2,
    ST_NEGATIVE  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_EVAL
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [FILE_W-1:0] file_id;
    logic [PAGE_W-1:0] page_number;
    logic [SLOT_W-1:0] slot;
  } entry_t;

endpackage

### rtl/psht_mod.sv
// Iterative remainder of the key sum magnitude by the bucket count, one byte per cycle.
module psht_mod #(
  parameter int BUCKETS = 64,
  localparam int RW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [psht_pkg::SUM_W-1:0] mag,
  output logic                     done,
  output logic [RW-1:0]            rem
);
  import psht_pkg::*;

  localparam logic [RW:0] BK = (RW + 1)'(BUCKETS);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PAD_W-1:0] sh_r, sh_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [RW-1:0]    step_rem;

  always_comb begin
    logic [RW:0]   t;
    logic [RW-1:0] r;
    r = rem_r;
    for (int i = 0; i < DIGIT_W; i++) begin
      t = {r, sh_r[PAD_W-1-i]};
      if (t >= BK) begin
        t = t - BK;
      end
      r = t[RW-1:0];
    end
    step_rem = r;
  end

  assign done = busy_r && (cnt_r == CNT_W'(DIGITS - 1));
  assign rem  = rem_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sh_nxt   = PAD_W'(mag);
      rem_nxt  = '0;
    end else if (busy_r) begin
      sh_nxt  = sh_r << DIGIT_W;
      rem_nxt = step_rem;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

endmodule

### rtl/page_slot_hash_table_unit.sv
// Top level of the page slot hash table: key hashing, bucket memory and request sequencing.
// Each item maps a (file_id, page_number) key to a bucket, the truncated remainder of
// their exact sum by BUCKETS, and searches, inserts or deletes among the WAYS entries of
// that bucket, all compared at once; a NOP changes nothing and a negative sum with a
// nonzero remainder gets ST_NEGATIVE. The remainder unit retires 8 bits of the 33-bit
// sum per cycle, then the READ state reads the bucket row and the EVAL state compares
// and writes it back. The next item is taken as soon as the result is registered, even
// while that result still waits on the output, and only in the idle state, so no item
// is taken while another is in progress. After reset the block clears one bucket row
// per cycle and accepts no item until every bucket row has been cleared.
module page_slot_hash_table_unit #(
  parameter int BUCKETS = 64,
  parameter int WAYS    = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // op[1:0], file_id[17:2], page_number[49:18], new_slot[59:50], zero [63:60]
  input  logic [psht_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status[2:0], found_slot[12:3], zero [15:13]
  output logic [psht_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import psht_pkg::*;

  localparam int RW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef entry_t [WAYS-1:0] row_t;

  state_t state_r, state_nxt;

  logic [OP_W-1:0]   in_op;
  logic [FILE_W-1:0] in_file;
  logic [PAGE_W-1:0] in_page;
  logic [SLOT_W-1:0] in_slot;
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]  mag;

  op_t               op_r;
  logic [FILE_W-1:0] file_r;
  logic [PAGE_W-1:0] page_r;
  logic [SLOT_W-1:0] slot_r;
  logic              neg_r;

  logic              mod_start;
  logic              mod_done;
  logic [RW-1:0]     bucket;

  logic [RW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic              clr_last;

  row_t              store_mem [BUCKETS];
  row_t              rd_row_r;
  logic              rd_en;
  logic              wr_en;
  logic [RW-1:0]     wr_addr;
  row_t              wr_row;

  logic              in_fire;
  logic              eval_act;
  logic              out_free;
  logic              eval_fire;

  status_t           res_status;
  logic [SLOT_W-1:0] res_slot;
  logic              row_wr;
  row_t              new_row;

  logic              out_tvalid_r;
  status_t           out_status_r;
  logic [SLOT_W-1:0] out_slot_r;

  assign in_op   = in_tdata[1:0];
  assign in_file = in_tdata[17:2];
  assign in_page = in_tdata[49:18];
  assign in_slot = in_tdata[59:50];

  assign sum = $signed({{(SUM_W - FILE_W){in_file[FILE_W-1]}}, in_file})
             + $signed({{(SUM_W - PAGE_W){in_page[PAGE_W-1]}}, in_page});
  assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign eval_fire = eval_act && out_free;
  assign clr_last  = (clr_cnt_r == RW'(BUCKETS - 1));

  psht_mod #(
    .BUCKETS(BUCKETS)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .mag   (mag),
    .done  (mod_done),
    .rem   (bucket)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (mod_done) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    mod_start = 1'b0;
    rd_en     = 1'b0;
    eval_act  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
      end
      S_IDLE: begin
        in_tready = 1'b1;
        mod_start = in_tvalid;
      end
      S_DIV: begin
      end
      S_READ: begin
        rd_en = 1'b1;
      end
      S_EVAL: begin
        eval_act = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign clr_cnt_nxt = (state_r == S_CLEAR) ? clr_cnt_r + RW'(1) : clr_cnt_r;

  always_comb begin
    logic [WAYS-1:0]  hit;
    logic             hit_any;
    logic [WAY_W-1:0] hit_idx;
    logic             free_any;
    logic [WAY_W-1:0] free_idx;
    logic             neg_key;
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit[w] = rd_row_r[w].valid && (rd_row_r[w].file_id == file_r)
            && (rd_row_r[w].page_number == page_r);
    end
    for (int w = 0; w < WAYS; w++) begin
      if (hit[w] && !hit_any) begin
        hit_any = 1'b1;
        hit_idx = WAY_W'(w);
      end
      if (!rd_row_r[w].valid && !free_any) begin
        free_any = 1'b1;
        free_idx = WAY_W'(w);
      end
    end
    neg_key    = neg_r && (bucket != '0);
    res_status = ST_OK;
    res_slot   = '0;
    row_wr     = 1'b0;
    new_row    = rd_row_r;
    if (op_r == OP_NOP) begin
      res_status = ST_OK;
    end else if (neg_key) begin
      res_status = ST_NEGATIVE;
    end else begin
      unique case (op_r)
        OP_SEARCH: begin
          if (hit_any) begin
            res_slot = rd_row_r[hit_idx].slot;
          end else begin
            res_status = ST_NOT_FOUND;
          end
        end
        OP_INSERT: begin
          if (hit_any) begin
            res_status = ST_REDUNDANT;
          end else if (free_any) begin
            row_wr                       = 1'b1;
            new_row[free_idx].valid       = 1'b1;
            new_row[free_idx].file_id     = file_r;
            new_row[free_idx].page_number = page_r;
            new_row[free_idx].slot        = slot_r;
          end else begin
            res_status = ST_FULL;
          end
        end
        OP_DELETE: begin
          if (hit_any) begin
            row_wr                 = 1'b1;
            new_row[hit_idx].valid = 1'b0;
          end
        end
        OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_row  = '0;
    end else begin
      wr_en   = eval_fire && row_wr;
      wr_addr = bucket;
      wr_row  = new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= store_mem[bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= op_t'(in_op);
      file_r <= in_file;
      page_r <= in_page;
      slot_r <= in_slot;
      neg_r  <= sum[SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (eval_fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eval_fire) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W - SLOT_W - STATUS_W){1'b0}}, out_slot_r, out_status_r};

endmodule
